>>> src/scintillator_coincidence_counter_macros.svh
// Assertion macros shared by the coincidence counter RTL.
`ifndef SCINTILLATOR_COINCIDENCE_COUNTER_MACROS_SVH
`define SCINTILLATOR_COINCIDENCE_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clk edge outside of reset.
`define SCC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");

// Check a property on every rising clk edge, reset included.
`define SCC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`else

`define SCC_ASSERT(label, prop)
`define SCC_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> src/scc_pkg.sv
// Types, constants and helpers of the scintillator coincidence counter.
package scc_pkg;

  localparam int SampleBitsDefault = 12;
  localparam int CountBitsDefault  = 32;

  localparam int NumDet = 4;
  localparam int NumCnt = 7;

  // Counter slots, in output order.
  localparam int CNT_TRIGGER    = 0;
  localparam int CNT_HIT_EVENT  = 1;
  localparam int CNT_FOURFOLD   = 2;
  localparam int CNT_UP         = 3;
  localparam int CNT_DOWN       = 4;
  localparam int CNT_UP_TIMED   = 5;
  localparam int CNT_DOWN_TIMED = 6;

  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits  = 30;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_HIT_THRESHOLD      = 2'd0,
    REG_COINCIDENCE_WINDOW = 2'd1,
    REG_SECOND_PERIOD      = 2'd2
  } reg_index_t;

  localparam logic [11:0] HitThresholdReset      = 12'd400;
  localparam logic [29:0] CoincidenceWindowReset = 30'd5800;
  localparam logic [29:0] SecondPeriodReset      = 30'd1000000000;

  typedef struct packed {
    logic [4:0]  channel;
    logic [11:0] sample;
    logic        end_of_event;
    logic [29:0] nanoseconds;
    logic [31:0] second_count;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  hit_mask;
    logic [11:0] max_a;
    logic [11:0] max_b;
    logic [11:0] max_c;
    logic [11:0] max_d;
    logic [31:0] trigger_total;
    logic [31:0] hit_event_total;
    logic [31:0] fourfold_total;
    logic [31:0] up_total;
    logic [31:0] down_total;
    logic [31:0] up_timed_total;
    logic [31:0] down_timed_total;
  } out_word_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] idx;
  } det_sel_t;

  // Map an ADC channel to its detector; unmapped channels give valid = 0.
  function automatic det_sel_t detector_of(logic [4:0] ch);
    det_sel_t sel;
    sel.valid = 1'b1;
    sel.idx   = 2'd0;
    if (ch <= 5'd5) begin
      sel.idx = 2'd0;
    end else if (ch <= 5'd11) begin
      sel.idx = 2'd1;
    end else if (ch >= 5'd18 && ch <= 5'd23) begin
      sel.idx = 2'd2;
    end else if (ch >= 5'd24 && ch <= 5'd29) begin
      sel.idx = 2'd3;
    end else begin
      sel.valid = 1'b0;
    end
    return sel;
  endfunction

endpackage

>>> src/scintillator_coincidence_counter.sv
// Top level of the scintillator coincidence counter.
//
// Usage:
//   in_valid/in_ready/in_data carry one ADC word per handshake: channel,
//   sample, end-of-event flag and the event time stamp. Channels 0-5, 6-11,
//   18-23 and 24-29 feed detectors A to D; other channels are ignored.
//   out_valid/out_ready/out_data deliver one result word per event, on the
//   word flagged end_of_event: hit mask, four peak samples and seven
//   saturating totals. Other words give no result.
//   cfg_write/cfg_index/cfg_data write hit_threshold (0), coincidence_window
//   (1) and second_period (2); other indexes are ignored. Write only while
//   the block is idle.
// Timing:
//   A word lands in the input register; compare, subtract and counter logic
//   then updates the event state and the result register: a result shows on
//   out_data once its end word leaves the input register into the result register.
//   One word per cycle is sustained; the input register advances each cycle
//   unless it holds an end word and the result register is still full.
// Reset (rst, synchronous): clears peaks, hit flags, totals, the previous
//   event time and both valid flags, and loads the register defaults.
// Stall: a stalled result holds out_data; non-end words keep flowing, and
//   in_ready drops only when an end word waits behind an untaken result.
module scintillator_coincidence_counter #(
  parameter int SAMPLE_BITS = scc_pkg::SampleBitsDefault,
  parameter int COUNT_BITS  = scc_pkg::CountBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  scc_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output scc_pkg::out_word_t                  out_data,
  input  logic                                cfg_write,
  input  logic [scc_pkg::CfgIndexBits-1:0]    cfg_index,
  input  logic [scc_pkg::CfgDataBits-1:0]     cfg_data
);

`include "scintillator_coincidence_counter_macros.svh"

  localparam int CmpBits = SAMPLE_BITS + 12;

  // Configuration registers
  logic [11:0] hit_threshold;
  logic [29:0] coincidence_window;
  logic [29:0] second_period;

  // Input register
  logic              s1_valid;
  scc_pkg::in_word_t s1_word;
  logic              s1_fire;

  // Event state
  logic [SAMPLE_BITS-1:0] peak [scc_pkg::NumDet];
  logic [SAMPLE_BITS-1:0] peak_next [scc_pkg::NumDet];
  logic [scc_pkg::NumDet-1:0] hit;
  logic [scc_pkg::NumDet-1:0] hit_next;
  logic        prev_ab_only;
  logic [29:0] prev_nanoseconds;
  logic [31:0] prev_seconds;
  logic [COUNT_BITS-1:0] cnt [scc_pkg::NumCnt];
  logic [COUNT_BITS-1:0] cnt_next [scc_pkg::NumCnt];
  logic [scc_pkg::NumCnt-1:0] cnt_inc;

  scc_pkg::det_sel_t      det;
  logic [CmpBits-1:0]     smp_wide;
  logic [SAMPLE_BITS-1:0] smp;
  logic                   smp_hit;
  logic                   ab_only;
  logic                   cd_only;
  logic signed [31:0]     delta;
  logic                   in_window;
  logic [11:0]            peak_out [scc_pkg::NumDet];
  logic [31:0]            cnt_out [scc_pkg::NumCnt];

  // Configuration writes; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold      <= scc_pkg::HitThresholdReset;
      coincidence_window <= scc_pkg::CoincidenceWindowReset;
      second_period      <= scc_pkg::SecondPeriodReset;
    end else if (cfg_write) begin
      case (cfg_index)
        scc_pkg::REG_HIT_THRESHOLD:      hit_threshold      <= cfg_data[11:0];
        scc_pkg::REG_COINCIDENCE_WINDOW: coincidence_window <= cfg_data;
        scc_pkg::REG_SECOND_PERIOD:      second_period      <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input register moves on unless it holds an end word that has no room.
  assign s1_fire  = s1_valid && (!s1_word.end_of_event || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word <= in_data;
    end
  end

  // Sample as SAMPLE_BITS wide: truncate or zero extend the 12 bit field.
  assign smp_wide = {{SAMPLE_BITS{1'b0}}, s1_word.sample};
  assign smp      = smp_wide[SAMPLE_BITS-1:0];
  assign smp_hit  = {{12{1'b0}}, smp} > {{SAMPLE_BITS{1'b0}}, hit_threshold};
  assign det      = scc_pkg::detector_of(s1_word.channel);

  // Fold this word into the selected detector.
  always_comb begin
    for (int k = 0; k < scc_pkg::NumDet; k++) begin
      peak_next[k] = peak[k];
      hit_next[k]  = hit[k];
      if (det.valid && det.idx == 2'(k)) begin
        if (smp > peak[k]) begin
          peak_next[k] = smp;
        end
        if (smp_hit) begin
          hit_next[k] = 1'b1;
        end
      end
    end
  end

  assign ab_only = hit_next[0] && hit_next[1] && !hit_next[2] && !hit_next[3];
  assign cd_only = !hit_next[0] && !hit_next[1] && hit_next[2] && hit_next[3];

  // Signed time since the last A-and-B-only event.
  assign delta = $signed({2'b00, s1_word.nanoseconds}) - $signed({2'b00, prev_nanoseconds})
               + ((s1_word.second_count != prev_seconds) ?
                  $signed({2'b00, second_period}) : 32'sd0);
  assign in_window = delta < $signed({2'b00, coincidence_window});

  always_comb begin
    cnt_inc = '0;
    cnt_inc[scc_pkg::CNT_TRIGGER]    = 1'b1;
    cnt_inc[scc_pkg::CNT_HIT_EVENT]  = |hit_next;
    cnt_inc[scc_pkg::CNT_FOURFOLD]   = &hit_next;
    cnt_inc[scc_pkg::CNT_UP]         = prev_ab_only && ab_only;
    cnt_inc[scc_pkg::CNT_DOWN]       = prev_ab_only && cd_only;
    cnt_inc[scc_pkg::CNT_UP_TIMED]   = prev_ab_only && ab_only && in_window;
    cnt_inc[scc_pkg::CNT_DOWN_TIMED] = prev_ab_only && cd_only && in_window;
  end

  // Saturating increments.
  always_comb begin
    for (int k = 0; k < scc_pkg::NumCnt; k++) begin
      cnt_next[k] = (cnt_inc[k] && cnt[k] != '1) ? cnt[k] + 1'b1 : cnt[k];
    end
  end

  // Advance the event state; clear the per-event part on the end word.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < scc_pkg::NumDet; k++) begin
        peak[k] <= '0;
      end
      hit <= '0;
      for (int k = 0; k < scc_pkg::NumCnt; k++) begin
        cnt[k] <= '0;
      end
      prev_ab_only     <= 1'b0;
      prev_nanoseconds <= '0;
      prev_seconds     <= '0;
    end else if (s1_fire) begin
      if (s1_word.end_of_event) begin
        for (int k = 0; k < scc_pkg::NumDet; k++) begin
          peak[k] <= '0;
        end
        hit <= '0;
        for (int k = 0; k < scc_pkg::NumCnt; k++) begin
          cnt[k] <= cnt_next[k];
        end
        prev_ab_only <= ab_only;
        if (ab_only) begin
          prev_nanoseconds <= s1_word.nanoseconds;
          prev_seconds     <= s1_word.second_count;
        end
      end else begin
        peak <= peak_next;
        hit  <= hit_next;
      end
    end
  end

  // Fit internal widths to the 12 and 32 bit result fields.
  always_comb begin
    logic [SAMPLE_BITS+11:0] pw;
    logic [COUNT_BITS+31:0]  cw;
    for (int k = 0; k < scc_pkg::NumDet; k++) begin
      pw          = {12'd0, peak_next[k]};
      peak_out[k] = pw[11:0];
    end
    for (int k = 0; k < scc_pkg::NumCnt; k++) begin
      cw         = {32'd0, cnt_next[k]};
      cnt_out[k] = cw[31:0];
    end
  end

  // Result register: load on an end word, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_word.end_of_event) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_word.end_of_event) begin
      out_data.hit_mask         <= hit_next;
      out_data.max_a            <= peak_out[0];
      out_data.max_b            <= peak_out[1];
      out_data.max_c            <= peak_out[2];
      out_data.max_d            <= peak_out[3];
      out_data.trigger_total    <= cnt_out[scc_pkg::CNT_TRIGGER];
      out_data.hit_event_total  <= cnt_out[scc_pkg::CNT_HIT_EVENT];
      out_data.fourfold_total   <= cnt_out[scc_pkg::CNT_FOURFOLD];
      out_data.up_total         <= cnt_out[scc_pkg::CNT_UP];
      out_data.down_total       <= cnt_out[scc_pkg::CNT_DOWN];
      out_data.up_timed_total   <= cnt_out[scc_pkg::CNT_UP_TIMED];
      out_data.down_timed_total <= cnt_out[scc_pkg::CNT_DOWN_TIMED];
    end
  end

  // Checks
  `SCC_ASSERT(a_trigger_monotonic,
    cnt[scc_pkg::CNT_TRIGGER] >= $past(cnt[scc_pkg::CNT_TRIGGER]))
  `SCC_ASSERT(a_hit_le_trigger,
    cnt[scc_pkg::CNT_HIT_EVENT] <= cnt[scc_pkg::CNT_TRIGGER])
  `SCC_ASSERT(a_up_timed_le_up,
    cnt[scc_pkg::CNT_UP_TIMED] <= cnt[scc_pkg::CNT_UP])
  `SCC_ASSERT(a_event_cleared,
    (s1_fire && s1_word.end_of_event) |=> (hit == '0 && peak[0] == '0))
  `SCC_ASSERT(a_no_result_mid_event,
    (s1_valid && !s1_word.end_of_event && out_valid && out_ready) |=> !out_valid)

endmodule
